@@ rtl/pott_pkg.sv @@
// shared types, widths and codes of the periodic and one-shot timer table
package pott_pkg;

	localparam int NUM_TIMERS_DEF = 64;
	localparam int MODE_W         = 2;
	localparam int TIME_W         = 64;
	localparam int DELAY_W        = 32;
	localparam int SLOT_W         = 6;
	localparam int TPU_W          = 12;
	localparam int PROD_W         = DELAY_W + TPU_W;

	localparam logic [TPU_W-1:0] TPU_RESET = 12'd24;

	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [TIME_W-1:0]  now;
		logic [DELAY_W-1:0] span_us;
		logic               repeat_req;
		logic [SLOT_W-1:0]  slot_to_cancel;
	} req_t;

	typedef struct packed {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic               status;
		logic [TIME_W-1:0]  tick_total;
		logic               last;
	} rsp_t;

	// write strobes of the slot memories
	typedef struct packed {
		logic exp_we;
		logic intv_we;
	} mem_wr_t;

endpackage

@@ rtl/pott_alu.sv @@
// shared arithmetic unit: registered interval product, expiry add and due compare
module pott_alu (
	input  logic                          clk,
	input  logic                          mul_en,
	input  logic [pott_pkg::DELAY_W-1:0]  mul_a,
	input  logic [pott_pkg::TPU_W-1:0]    mul_b,
	input  logic [pott_pkg::TIME_W-1:0]   now,
	input  logic [pott_pkg::TIME_W-1:0]   expiry,
	output logic [pott_pkg::TIME_W-1:0]   sum,
	output logic                          due
);
	import pott_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// wraps modulo 2^64
	assign sum = now + TIME_W'(prod_q);
	assign due = (now >= expiry);

endmodule

@@ rtl/pott_mem.sv @@
// slot memories: expiry time, and interval with periodic flag
module pott_mem #(
	parameter int NUM_TIMERS = pott_pkg::NUM_TIMERS_DEF,
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic                           clk,
	input  pott_pkg::mem_wr_t              wr,
	input  logic [IDX_W-1:0]               wr_addr,
	input  logic [pott_pkg::TIME_W-1:0]    exp_wdata,
	input  logic [pott_pkg::DELAY_W:0]     intv_wdata,
	input  logic [IDX_W-1:0]               rd_addr,
	output logic [pott_pkg::TIME_W-1:0]    exp_rdata,
	output logic [pott_pkg::DELAY_W:0]     intv_rdata
);
	import pott_pkg::*;

	logic [TIME_W-1:0] exp_mem [NUM_TIMERS];
	// msb is the periodic flag
	logic [DELAY_W:0]  intv_mem [NUM_TIMERS];

	always_ff @(posedge clk) begin
		if (wr.exp_we) begin
			exp_mem[wr_addr] <= exp_wdata;
		end
		if (wr.intv_we) begin
			intv_mem[wr_addr] <= intv_wdata;
		end
	end

	always_ff @(posedge clk) begin
		exp_rdata  <= exp_mem[rd_addr];
		intv_rdata <= intv_mem[rd_addr];
	end

endmodule

@@ rtl/periodic_oneshot_timer_table.sv @@
// top level of the timer table: sequencer, armed flags, tick count and result register
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------
//  req     | in        | req_valid/req_stall| pott_pkg::req_t, one command
//  rsp     | out       | rsp_valid/rsp_stall| pott_pkg::rsp_t, reply or report
//  cfg     | in        | cfg_valid/cfg_ready| ticks_per_us, 12 bits
//
// cancel and unused modes finish in the idle state; create passes S_CMUL and S_CWR.
// a tick visits S_RD for every slot, then S_CHK for an armed slot and S_UPD for a
// due slot, and ends in S_DONE; the single read port of the slot memories and the
// shared multiplier set this order of steps.
// arst_n clears the sequencer, armed flags, tick count and ticks_per_us (24).
// rsp_stall holds a create or the scan only when a word has to go out and the
// result register is still full.
module periodic_oneshot_timer_table #(
	parameter int NUM_TIMERS = pott_pkg::NUM_TIMERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  pott_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output pott_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pott_pkg::TPU_W-1:0]  cfg_data
);
	import pott_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMUL = 3'd1;
	localparam logic [2:0] S_CWR  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]            state_q;
	req_t                  req_q;
	logic [TPU_W-1:0]      tpu_q;
	logic [TIME_W-1:0]     tick_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  full_q;
	logic                  pend_valid_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [IDX_W-1:0]      idx;
	logic                  accept;
	logic                  out_free;
	logic                  emit;
	rsp_t                  rsp_d;
	logic [IDX_W-1:0]      free_idx;
	logic                  any_free;

	mem_wr_t               mem_wr;
	logic [IDX_W-1:0]      wr_addr;
	logic [TIME_W-1:0]     exp_rdata;
	logic [DELAY_W:0]      intv_rdata;
	logic                  mul_en;
	logic [DELAY_W-1:0]    mul_a;
	logic [TIME_W-1:0]     sum;
	logic                  due;

	assign idx       = cnt_q[IDX_W-1:0];
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// lowest unarmed slot
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!armed_q[i]) begin
				free_idx = IDX_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign mul_en  = (state_q == S_CMUL) || (state_q == S_CHK);
	assign mul_a   = (state_q == S_CMUL) ? req_q.span_us : intv_rdata[DELAY_W-1:0];
	assign wr_addr = (state_q == S_CWR) ? free_idx_q : idx;

	always_comb begin
		mem_wr = '0;
		if (state_q == S_CWR && out_free && !full_q) begin
			mem_wr.exp_we  = 1'b1;
			mem_wr.intv_we = 1'b1;
		end
		if (state_q == S_UPD && (!pend_valid_q || out_free) && intv_rdata[DELAY_W]) begin
			mem_wr.exp_we = 1'b1;
		end
	end

	pott_alu u_alu (
		.clk    (clk),
		.mul_en (mul_en),
		.mul_a  (mul_a),
		.mul_b  (tpu_q),
		.now    (req_q.now),
		.expiry (exp_rdata),
		.sum    (sum),
		.due    (due)
	);

	pott_mem #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_mem (
		.clk        (clk),
		.wr         (mem_wr),
		.wr_addr    (wr_addr),
		.exp_wdata  (sum),
		.intv_wdata ({req_q.repeat_req, req_q.span_us}),
		.rd_addr    (idx),
		.exp_rdata  (exp_rdata),
		.intv_rdata (intv_rdata)
	);

	// result word to send this cycle
	always_comb begin
		emit  = 1'b0;
		rsp_d = '0;
		rsp_d.tick_total = tick_q;
		case (state_q)
			S_CWR: begin
				emit         = out_free;
				rsp_d.kind   = KIND_REPLY;
				rsp_d.slot   = full_q ? '0 : SLOT_W'(free_idx_q);
				rsp_d.status = full_q ? STATUS_FULL : STATUS_OK;
				rsp_d.last   = 1'b1;
			end
			S_UPD, S_DONE: begin
				emit         = pend_valid_q && out_free;
				rsp_d.kind   = KIND_EXPIRY;
				rsp_d.slot   = SLOT_W'(pend_idx_q);
				rsp_d.status = STATUS_OK;
				rsp_d.last   = (state_q == S_DONE);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
		if (state_q == S_CMUL) begin
			free_idx_q <= free_idx;
			full_q     <= !any_free;
		end
		if (state_q == S_UPD && (!pend_valid_q || out_free)) begin
			pend_idx_q <= idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tpu_q        <= TPU_RESET;
			tick_q       <= '0;
			armed_q      <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tpu_q <= cfg_data;
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.mode)
							MODE_TICK: begin
								tick_q       <= tick_q + 1'b1;
								cnt_q        <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= S_RD;
							end
							MODE_CREATE: begin
								state_q <= S_CMUL;
							end
							MODE_CANCEL: begin
								if (32'(req.slot_to_cancel) < NUM_TIMERS) begin
									armed_q[req.slot_to_cancel[IDX_W-1:0]] <= 1'b0;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CMUL: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if (out_free) begin
						if (!full_q) begin
							armed_q[free_idx_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					if (cnt_q == CNT_W'(NUM_TIMERS)) begin
						state_q <= S_DONE;
					end else if (!armed_q[idx]) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (due) begin
						state_q <= S_UPD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_UPD: begin
					// previous report leaves with last clear before this one is held
					if (!pend_valid_q || out_free) begin
						if (!intv_rdata[DELAY_W]) begin
							armed_q[idx] <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						cnt_q        <= cnt_q + 1'b1;
						state_q      <= S_RD;
					end
				end
				S_DONE: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/pott_checker.sv @@
// port checks of the timer table and their binding
module pott_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input pott_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pott_pkg::rsp_t rsp
);
	import pott_pkg::*;

	// a create reply is always the only word of its command
	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_REPLY) |-> rsp.last)
		else $error("create reply without last");

	// no-free status only on a create reply, with slot zero
	a_full_reply: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_FULL) |->
			(rsp.kind == KIND_REPLY) && (rsp.slot == '0))
		else $error("bad no-free-slot word");

	// tick and create keep the block busy on the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && ((req.mode == MODE_TICK) || (req.mode == MODE_CREATE))
			|=> req_stall)
		else $error("command accepted without going busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

endmodule

bind periodic_oneshot_timer_table pott_checker u_pott_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
